// ===== rtl/core/prlt_pkg.sv =====
`timescale 1ns / 1ps
package prlt_pkg;
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    OC_STORED    = 3'd0,
    OC_DUPLICATE = 3'd1,
    OC_FULL      = 3'd2,
    OC_MATCHED   = 3'd3,
    OC_UNKNOWN   = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WRITE,
    ST_DONE
  } state_t;
endpackage

// ===== rtl/core/pending_request_latency_tracker_core.sv =====
`timescale 1ns / 1ps
// Pending request latency tracker. Issue one event per start beat (start high
// while busy is low); busy stays high until the result beat. The table is a
// single-port memory scanned one slot at a time (read, then compare), so busy
// stays high through the scan of the N slots probed (at most TABLE_ENTRIES)
// and then a write state and a done state; the result beat follows, and the
// next event can be accepted at the edge that takes it. The serial scan
// through the memory read port sets the busy time; a scan stops at its first
// match (a duplicate send or confirmed slot), else scans the whole table. The
// result appears for one cycle with done high and cannot be stalled: the
// receiver must take it in that cycle. Valid marks live in the memory words;
// after reset a pass over every slot holds busy high while it clears them.
module pending_request_latency_tracker_core import prlt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic signed [63:0] request_id,
  input  logic [7:0]         reply_status,
  input  logic [63:0]        time_now,
  output logic               done,
  output logic [2:0]         outcome,
  output logic signed [63:0] echo_id,
  output logic [7:0]         echo_status,
  output logic [63:0]        sent_at,
  output logic [63:0]        received_at,
  output logic [63:0]        elapsed,
  output logic [31:0]        samples_taken,
  output logic [10:0]        pending_count
);

  // Table storage: valid mark, id and send time in one memory word.
  logic [128:0] mem [TABLE_ENTRIES];
  logic [128:0] rd_data;
  logic         mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [128:0] mem_wdata;

  state_t state, state_next;

  // Captured event.
  logic        c_cmd;
  logic [63:0] c_id;
  logic [7:0]  c_status;
  logic [63:0] c_time;

  // Scan control.
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] hit_idx;
  logic             hit;
  logic [IDX_W-1:0] free_idx;
  logic             free_found;
  logic [63:0]      hit_time;
  logic [31:0]      match_counter;
  logic [CNT_W-1:0] occupancy;
  logic             last;
  logic             slot_hit;

  assign last = (idx == IDX_W'(TABLE_ENTRIES - 1));
  assign slot_hit = rd_data[128] && (rd_data[127:64] == c_id);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (last) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_READ;
      ST_READ:  state_next = ST_CMP;
      ST_CMP: begin
        if (slot_hit || last) state_next = ST_WRITE;
        else state_next = ST_READ;
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy = (state != ST_IDLE);
  end

  // Memory write port: clear during the pass after reset, else one update.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    unique case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_WRITE: begin
        if (c_cmd && hit) begin
          mem_we    = 1'b1;
          mem_waddr = hit_idx;
          mem_wdata = {1'b0, c_id, hit_time};
        end else if (!c_cmd && !hit && free_found) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx;
          mem_wdata = {1'b1, c_id, c_time};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // Registered memory read and write.
  always_ff @(posedge clk) begin
    if (state == ST_READ) rd_data <= mem[idx];
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_counter <= '0;
      occupancy <= '0;
      done <= 1'b0;
      idx <= '0;
      hit <= 1'b0;
      free_found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: idx <= idx + 1'b1;
        ST_IDLE: if (start) begin
          c_cmd <= cmd;
          c_id <= request_id;
          c_status <= reply_status;
          c_time <= time_now;
          idx <= '0;
          hit <= 1'b0;
          free_found <= 1'b0;
        end
        ST_CMP: begin
          // Track lowest free slot alongside the scan.
          if (!rd_data[128] && !free_found) begin
            free_found <= 1'b1;
            free_idx <= idx;
          end
          if (slot_hit) begin
            hit <= 1'b1;
            hit_idx <= idx;
            hit_time <= rd_data[63:0];
          end
          idx <= idx + 1'b1;
        end
        ST_WRITE: begin
          if (c_cmd) begin
            if (hit) begin
              if (occupancy != '0) occupancy <= occupancy - 1'b1;
              if (match_counter != '1) match_counter <= match_counter + 1'b1;
            end
          end else if (!hit && free_found) begin
            occupancy <= occupancy + 1'b1;
          end
        end
        ST_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  // Result registers, loaded as the result beat goes out.
  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      echo_id <= c_id;
      samples_taken <= match_counter;
      pending_count <= 11'(occupancy);
      if (c_cmd && hit) begin
        outcome <= OC_MATCHED;
        echo_status <= c_status;
        sent_at <= hit_time;
        received_at <= c_time;
        elapsed <= c_time - hit_time;
      end else begin
        echo_status <= '0;
        sent_at <= '0;
        received_at <= '0;
        elapsed <= '0;
        if (c_cmd) outcome <= OC_UNKNOWN;
        else if (hit) outcome <= OC_DUPLICATE;
        else if (free_found) outcome <= OC_STORED;
        else outcome <= OC_FULL;
      end
    end
  end

endmodule

// ===== tb/sv/pending_request_latency_tracker_core_tb.sv =====
`timescale 1ns / 1ps
module pending_request_latency_tracker_core_tb;
  import prlt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // One expected or one observed result.
  typedef struct packed {
    logic [2:0]  outcome;
    logic [63:0] echo_id;
    logic [7:0]  echo_status;
    logic [63:0] sent_at;
    logic [63:0] received_at;
    logic [63:0] elapsed;
    logic [31:0] samples_taken;
    logic [10:0] pending_count;
  } tracker_result_t;

  // Tracks the pending table and the queue of expected result beats.
  class latency_scoreboard;
    logic [63:0]     pend_time [logic [63:0]];
    logic [31:0]     match_cnt;
    tracker_result_t expected_q[$];
    int              mismatches;

    function new();
      match_cnt  = 0;
      mismatches = 0;
    endfunction

    // Predict the result of an accepted event beat.
    function void note_event(logic c, logic [63:0] id, logic [7:0] st, logic [63:0] now);
      tracker_result_t r;
      r = '0;
      r.echo_id = id;
      if (c == 1'b0) begin
        if (pend_time.exists(id)) r.outcome = OC_DUPLICATE;
        else if (pend_time.num() >= TABLE_ENTRIES) r.outcome = OC_FULL;
        else begin
          pend_time[id] = now;
          r.outcome = OC_STORED;
        end
      end else begin
        if (!pend_time.exists(id)) r.outcome = OC_UNKNOWN;
        else begin
          r.outcome     = OC_MATCHED;
          r.echo_status = st;
          r.sent_at     = pend_time[id];
          r.received_at = now;
          r.elapsed     = now - pend_time[id];
          pend_time.delete(id);
          if (match_cnt != 32'hFFFF_FFFF) match_cnt++;
        end
      end
      r.samples_taken = match_cnt;
      r.pending_count = 11'(pend_time.num());
      expected_q = {expected_q, r};
    endfunction

    // Compare a result beat with the oldest expectation.
    function void check_result(tracker_result_t got);
      tracker_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch id %h: outcome %0d/%0d status %h/%h sent %h/%h",
                   exp_r.echo_id, exp_r.outcome, got.outcome, exp_r.echo_status,
                   got.echo_status, exp_r.sent_at, got.sent_at);
          $display("  recv %h/%h elapsed %h/%h samples %0d/%0d pending %0d/%0d",
                   exp_r.received_at, got.received_at, exp_r.elapsed, got.elapsed,
                   exp_r.samples_taken, got.samples_taken, exp_r.pending_count,
                   got.pending_count);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               cmd;
  logic signed [63:0] request_id;
  logic [7:0]         reply_status;
  logic [63:0]        time_now;
  logic               done;
  logic [2:0]         outcome;
  logic signed [63:0] echo_id;
  logic [7:0]         echo_status;
  logic [63:0]        sent_at;
  logic [63:0]        received_at;
  logic [63:0]        elapsed;
  logic [31:0]        samples_taken;
  logic [10:0]        pending_count;

  latency_scoreboard sb;
  int                idle_cycles;
  bit                no_idle;

  pending_request_latency_tracker_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .request_id(request_id), .reply_status(reply_status), .time_now(time_now),
    .done(done), .outcome(outcome), .echo_id(echo_id), .echo_status(echo_status),
    .sent_at(sent_at), .received_at(received_at), .elapsed(elapsed),
    .samples_taken(samples_taken), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = 1'b0;
    request_id   = '0;
    reply_status = '0;
    time_now     = '0;
  end

  // Sample result beats; the receiver cannot stall, so take every done cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result({outcome, echo_id, echo_status, sent_at, received_at,
                       elapsed, samples_taken, pending_count});
    end
  end

  // Watchdog: count cycles with no beat accepted on either side.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Issue one event beat and hold start until accepted. Start stays high
  // into the next call; drop it only when this call idles first.
  task automatic send_event(logic c, logic [63:0] id, logic [7:0] st, logic [63:0] now);
    if (!no_idle && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 29) @(posedge clk);
    end
    start        <= 1'b1;
    cmd          <= c;
    request_id   <= id;
    reply_status <= st;
    time_now     <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_event(c, id, st, now);
  endtask

  initial begin
    sb          = new();
    idle_cycles = 0;
    no_idle     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of id and time, each outcome but full, wrapping elapsed.
    send_event(1'b0, 64'h8000_0000_0000_0000, 8'h00, 64'hFFFF_FFFF_FFFF_FFF0);
    send_event(1'b0, 64'h8000_0000_0000_0000, 8'hFF, 64'd5);
    send_event(1'b1, 64'h8000_0000_0000_0000, 8'hFF, 64'd20);
    send_event(1'b1, 64'h8000_0000_0000_0000, 8'hA5, 64'd21);
    send_event(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 64'd0);
    send_event(1'b0, 64'd0, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h5A, 64'h5555_5555_5555_5555);
    send_event(1'b1, 64'd0, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 8'h80, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h01, 64'hAAAA_AAAA_AAAA_AAAA);
    send_event(1'b1, 64'd12345, 8'h33, 64'd99);

    // Fill the table to capacity with random send times, the first half
    // back to back, then hit the full-table case.
    no_idle = 1'b1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (i == TABLE_ENTRIES / 2) no_idle = 1'b0;
      send_event(1'b0, 64'(i), 8'($urandom_range(255)), {$urandom, $urandom});
    end
    send_event(1'b0, 64'hDEAD_BEEF, 8'h00, 64'd7);
    send_event(1'b0, 64'd5, 8'h00, 64'd7);
    send_event(1'b1, 64'd5, 8'h77, {$urandom, $urandom});
    send_event(1'b0, 64'hDEAD_BEEF, 8'h00, 64'd101);
    send_event(1'b1, 64'hDEAD_BEEF, 8'hC3, 64'd0);
    send_event(1'b1, 64'hDEAD_BEEF, 8'h3C, 64'd2);
    start <= 1'b0;

    // Drain outstanding results, then a short tail.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
